@@ design/mglt_pkg.sv @@
// Shared types, codes and mode tables for the lock table.
`timescale 1ns / 1ps
`default_nettype none
package mglt_pkg;

	localparam int KEY_W   = 49;
	localparam int TXN_W   = 16;
	localparam int MODE_W  = 3;
	localparam int HIDX_W  = 5;
	localparam int NUM_OBJECTS_DEF        = 16;
	localparam int HOLDERS_PER_OBJECT_DEF = 4;

	localparam logic [2:0] CMD_REC_S  = 3'd0;
	localparam logic [2:0] CMD_REC_X  = 3'd1;
	localparam logic [2:0] CMD_TAB_S  = 3'd2;
	localparam logic [2:0] CMD_TAB_X  = 3'd3;
	localparam logic [2:0] CMD_TAB_IS = 3'd4;
	localparam logic [2:0] CMD_TAB_IX = 3'd5;
	localparam logic [2:0] CMD_UNLOCK = 3'd6;
	localparam logic [2:0] CMD_NONE   = 3'd7;

	localparam logic [2:0] M_NONE = 3'd0;
	localparam logic [2:0] M_S    = 3'd1;
	localparam logic [2:0] M_X    = 3'd2;
	localparam logic [2:0] M_IS   = 3'd3;
	localparam logic [2:0] M_IX   = 3'd4;
	localparam logic [2:0] M_SIX  = 3'd5;

	localparam logic [2:0] ST_GRANTED  = 3'd0;
	localparam logic [2:0] ST_HELD     = 3'd1;
	localparam logic [2:0] ST_UPGRADED = 3'd2;
	localparam logic [2:0] ST_ABORT    = 3'd3;
	localparam logic [2:0] ST_ABORT_UP = 3'd4;
	localparam logic [2:0] ST_UNLOCKED = 3'd5;
	localparam logic [2:0] ST_NOTFOUND = 3'd6;
	localparam logic [2:0] ST_FULL     = 3'd7;

	typedef enum logic [2:0] {
		OP_NONE    = 3'd0,
		OP_ALLOC   = 3'd1,
		OP_ADD     = 3'd2,
		OP_UPGRADE = 3'd3,
		OP_REMOVE  = 3'd4
	} op_kind_t;

	typedef struct packed {
		logic              hit;
		logic              mine_found;
		logic [HIDX_W-1:0] mine_idx;
		logic [MODE_W-1:0] cur_mode;
		logic              free_found;
		logic [HIDX_W-1:0] free_idx;
		logic [7:0]        others;
		logic              others_any;
	} cell_sum_t;

	typedef struct packed {
		op_kind_t          kind;
		logic [HIDX_W-1:0] hidx;
		logic [MODE_W-1:0] mode;
		logic              keep_entry;
	} cell_op_t;

	function automatic logic [7:0] conflict_set(input logic [2:0] m);
		logic [7:0] r;
		r = 8'd0;
		case (m)
			M_S:   r = 8'b0011_0100;
			M_X:   r = 8'b0011_1110;
			M_IS:  r = 8'b0000_0100;
			M_IX:  r = 8'b0010_0110;
			M_SIX: r = 8'b0011_0110;
			default: r = 8'd0;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] cover_mode(input logic [2:0] a, input logic [2:0] b);
		logic [2:0] r;
		if (a == M_NONE) r = b;
		else if (a == b) r = a;
		else if (a == M_X || b == M_X) r = M_X;
		else if (a == M_SIX || b == M_SIX) r = M_SIX;
		else if ((a == M_S && b == M_IX) || (a == M_IX && b == M_S)) r = M_SIX;
		else if (a == M_IS) r = b;
		else if (b == M_IS) r = a;
		else r = M_X;
		return r;
	endfunction

endpackage
`default_nettype wire

@@ design/mglt_cell.sv @@
// One lock table entry: key, holder slots, lookup summary and free-entry chain link.
`timescale 1ns / 1ps
`default_nettype none
module mglt_cell #(
	parameter int HOLDERS = mglt_pkg::HOLDERS_PER_OBJECT_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          look,
	input  wire [mglt_pkg::KEY_W-1:0]    key,
	input  wire [mglt_pkg::TXN_W-1:0]    txn,
	input  wire                          free_in,
	output logic                         free_out,
	output logic                         first_free,
	output mglt_pkg::cell_sum_t          sum,
	input  wire                          wr,
	input  wire                          sel,
	input  wire mglt_pkg::cell_op_t      op
);
	localparam int HW = (HOLDERS > 1) ? $clog2(HOLDERS) : 1;

	logic                          valid_q;
	logic [mglt_pkg::KEY_W-1:0]    key_q;
	logic [HOLDERS-1:0]            hv_q;
	logic [mglt_pkg::TXN_W-1:0]    htxn_q [HOLDERS];
	logic [mglt_pkg::MODE_W-1:0]   hmode_q [HOLDERS];
	mglt_pkg::cell_sum_t           sum_q;
	mglt_pkg::cell_sum_t           sum_d;

	assign free_out   = free_in | ~valid_q;
	assign first_free = ~valid_q & ~free_in;
	assign sum        = sum_q;

	always_comb begin
		sum_d = '0;
		sum_d.hit = valid_q && (key_q == key);
		for (int h = HOLDERS - 1; h >= 0; h--) begin
			if (!hv_q[h]) begin
				sum_d.free_found = 1'b1;
				sum_d.free_idx   = mglt_pkg::HIDX_W'(h);
			end
		end
		for (int h = HOLDERS - 1; h >= 0; h--) begin
			if (hv_q[h] && htxn_q[h] == txn) begin
				sum_d.mine_found = 1'b1;
				sum_d.mine_idx   = mglt_pkg::HIDX_W'(h);
				sum_d.cur_mode   = hmode_q[h];
			end
		end
		for (int h = 0; h < HOLDERS; h++) begin
			if (hv_q[h] && htxn_q[h] != txn) begin
				sum_d.others     = sum_d.others | (8'd1 << hmode_q[h]);
				sum_d.others_any = 1'b1;
			end
		end
		if (!sum_d.hit) sum_d = '0;
	end

	always_ff @(posedge clk) begin
		if (look) sum_q <= sum_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hv_q    <= '0;
		end else if (wr && sel) begin
			unique case (op.kind)
				mglt_pkg::OP_ALLOC: begin
					valid_q <= 1'b1;
					hv_q    <= HOLDERS'(1);
				end
				mglt_pkg::OP_ADD: hv_q[op.hidx[HW-1:0]] <= 1'b1;
				mglt_pkg::OP_REMOVE: begin
					hv_q[op.hidx[HW-1:0]] <= 1'b0;
					valid_q <= op.keep_entry;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr && sel) begin
			case (op.kind)
				mglt_pkg::OP_ALLOC: begin
					key_q      <= key;
					htxn_q[0]  <= txn;
					hmode_q[0] <= op.mode;
				end
				mglt_pkg::OP_ADD: begin
					htxn_q[op.hidx[HW-1:0]]  <= txn;
					hmode_q[op.hidx[HW-1:0]] <= op.mode;
				end
				mglt_pkg::OP_UPGRADE: hmode_q[op.hidx[HW-1:0]] <= op.mode;
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ design/multigranularity_lock_table.sv @@
// Top level of the no-wait multiple-granularity lock table.
// A request is handled in order: accept, parallel key and holder lookup in every
// entry cell, decision on the matched entry, and write back with the result word loaded
// into the output register. The next request is taken only after write back, since
// it depends on the updated table. A stalled output holds the write back stage.
// Reset clears all entry and holder valid bits at once.
`timescale 1ns / 1ps
`default_nettype none
module multigranularity_lock_table #(
	parameter int NUM_OBJECTS        = mglt_pkg::NUM_OBJECTS_DEF,
	parameter int HOLDERS_PER_OBJECT = mglt_pkg::HOLDERS_PER_OBJECT_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire [63:0] s_tdata,  // txn_id, table_id, record_page, record_slot
	input  wire [3:0]  s_tuser,  // command, object_is_record
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [7:0] m_tdata   // status, held_mode, zero pad
);
	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_LOOK   = 4'b0010,
		S_DECIDE = 4'b0100,
		S_WRITE  = 4'b1000
	} state_t;

	state_t                       state_q;
	logic [2:0]                   cmd_q;
	logic [mglt_pkg::TXN_W-1:0]   txn_q;
	logic [mglt_pkg::KEY_W-1:0]   key_q;
	logic [NUM_OBJECTS-1:0]       hit_vec;
	logic [NUM_OBJECTS-1:0]       ff_vec;
	logic [NUM_OBJECTS:0]         free_chain;
	logic [NUM_OBJECTS-1:0]       target_q;
	mglt_pkg::cell_sum_t          sums [NUM_OBJECTS];
	mglt_pkg::cell_sum_t          hs;
	mglt_pkg::cell_op_t           op_d, op_q;
	logic [2:0]                   st_d, st_q, md_d, md_q;
	logic                         any_hit, any_free, wr;
	logic [2:0]                   req, cur, nxt;
	logic                         is_rec;
	logic                         out_valid_q;
	logic [7:0]                   out_q;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;
	assign wr = (state_q == S_WRITE) && (!out_valid_q || m_tready);
	assign free_chain[0] = 1'b0;

	always_comb begin
		is_rec = (s_tuser[2:0] == mglt_pkg::CMD_UNLOCK) ? s_tuser[3]
			: (s_tuser[2:0] == mglt_pkg::CMD_REC_S || s_tuser[2:0] == mglt_pkg::CMD_REC_X);
	end

	genvar gi;
	generate
		for (gi = 0; gi < NUM_OBJECTS; gi++) begin : g_cell
			mglt_cell #(.HOLDERS(HOLDERS_PER_OBJECT)) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.look       (state_q == S_LOOK),
				.key        (key_q),
				.txn        (txn_q),
				.free_in    (free_chain[gi]),
				.free_out   (free_chain[gi+1]),
				.first_free (ff_vec[gi]),
				.sum        (sums[gi]),
				.wr         (wr),
				.sel        (target_q[gi]),
				.op         (op_q)
			);
			assign hit_vec[gi] = sums[gi].hit;
		end
	endgenerate

	always_comb begin
		hs = '0;
		for (int i = 0; i < NUM_OBJECTS; i++) hs = hs | sums[i];
		any_hit  = |hit_vec;
		any_free = |ff_vec;
		unique case (cmd_q)
			mglt_pkg::CMD_REC_S, mglt_pkg::CMD_TAB_S: req = mglt_pkg::M_S;
			mglt_pkg::CMD_REC_X, mglt_pkg::CMD_TAB_X: req = mglt_pkg::M_X;
			mglt_pkg::CMD_TAB_IS:                     req = mglt_pkg::M_IS;
			default:                                  req = mglt_pkg::M_IX;
		endcase
		cur = hs.mine_found ? hs.cur_mode : mglt_pkg::M_NONE;
		nxt = mglt_pkg::cover_mode(cur, req);
		op_d = '{kind: mglt_pkg::OP_NONE, hidx: hs.free_idx, mode: req,
			keep_entry: hs.others_any};
		st_d = mglt_pkg::ST_NOTFOUND;
		md_d = mglt_pkg::M_NONE;
		if (cmd_q == mglt_pkg::CMD_NONE) begin
			st_d = mglt_pkg::ST_NOTFOUND;
		end else if (cmd_q == mglt_pkg::CMD_UNLOCK) begin
			if (any_hit && hs.mine_found) begin
				st_d = mglt_pkg::ST_UNLOCKED;
				op_d.kind = mglt_pkg::OP_REMOVE;
				op_d.hidx = hs.mine_idx;
			end
		end else if (!any_hit) begin
			if (!any_free) begin
				st_d = mglt_pkg::ST_FULL;
			end else begin
				st_d = mglt_pkg::ST_GRANTED;
				md_d = req;
				op_d.kind = mglt_pkg::OP_ALLOC;
			end
		end else if (nxt == cur) begin
			st_d = mglt_pkg::ST_HELD;
			md_d = cur;
		end else if (cur == mglt_pkg::M_NONE) begin
			if ((hs.others & mglt_pkg::conflict_set(req)) != 8'd0) begin
				st_d = mglt_pkg::ST_ABORT;
			end else if (!hs.free_found) begin
				st_d = mglt_pkg::ST_FULL;
			end else begin
				st_d = mglt_pkg::ST_GRANTED;
				md_d = req;
				op_d.kind = mglt_pkg::OP_ADD;
			end
		end else if ((hs.others & mglt_pkg::conflict_set(nxt)) != 8'd0) begin
			st_d = mglt_pkg::ST_ABORT_UP;
			md_d = cur;
		end else begin
			st_d = mglt_pkg::ST_UPGRADED;
			md_d = nxt;
			op_d.kind = mglt_pkg::OP_UPGRADE;
			op_d.hidx = hs.mine_idx;
			op_d.mode = nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			target_q    <= '0;
		end else begin
			if (wr) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE:   if (s_tvalid) state_q <= S_LOOK;
				S_LOOK:   state_q <= S_DECIDE;
				S_DECIDE: begin
					state_q  <= S_WRITE;
					target_q <= any_hit ? hit_vec : ff_vec;
				end
				S_WRITE: if (wr) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q <= s_tuser[2:0];
			txn_q <= s_tdata[15:0];
			key_q <= is_rec ? {1'b1, s_tdata[63:56], s_tdata[55:48], s_tdata[47:24],
				s_tdata[23:16]} : {41'd0, s_tdata[23:16]};
		end
		if (state_q == S_DECIDE) begin
			op_q <= op_d;
			st_q <= st_d;
			md_q <= md_d;
		end
		if (wr) out_q <= {2'b00, md_q, st_q};
	end

	a_one_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE) |-> $onehot0(hit_vec))
		else $error("more than one entry matches the key");
	a_one_target: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRITE) |-> $onehot0(target_q))
		else $error("write back targets several entries");
	a_decide_next: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE) |=> (state_q == S_WRITE))
		else $error("decision not followed by write back");
	a_free_write: assert property (@(posedge clk) disable iff (!arst_n)
		(wr && op_q.kind == mglt_pkg::OP_ALLOC) |-> (target_q & hit_vec) == '0)
		else $error("allocation over a matched entry");

endmodule
`default_nettype wire
